### hw/rtl/tlpt_pkg.sv
package tlpt_pkg;

   // One level of the walk: 1024 entries, 10 index bits, 12 offset bits
   localparam int unsigned ENTRIES = 1024;
   localparam int unsigned IDX_W   = 10;
   localparam int unsigned OFF_W   = 12;
   localparam int unsigned FRAME_W = 32 - OFF_W;

   localparam logic [OFF_W-1:0] FLAG_PRESENT  = 12'h001;
   localparam logic [OFF_W-1:0] FLAG_RW       = 12'h002;
   localparam logic [OFF_W-1:0] DIR_ABSENT    = 12'h002;
   localparam logic [OFF_W-1:0] DIR_FIRST     = 12'h003;
   localparam logic [OFF_W-1:0] IDENT_FLAGS   = 12'h003;

   typedef enum logic [1:0] {
      CMD_MAP       = 2'd0,
      CMD_UNMAP     = 2'd1,
      CMD_TRANSLATE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_DONE     = 2'd0,
      STAT_UNMAPPED = 2'd1,
      STAT_NO_TABLE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIR,
      ST_TAB,
      ST_RESP
   } state_type;

endpackage

### hw/rtl/tlpt_ram.sv
module tlpt_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/two_level_page_table.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  command, virt_addr, phys_addr_in, entry_flags
// rsp_      out        rsp_valid / rsp_stall  phys_addr_out, status
//
// Steps: map, unmap and unused commands pass through accept with directory read,
// directory check with any writes, and result; a translate that finds its directory
// entry adds the dependent table read before the result. Each memory read is registered.
// Reset: a clearing pass over TABLE_SLOTS*1024 addresses (16384 by default) writes both
// memories' reset contents with req_stall high. Stalls: req_stall is high while a
// transaction is in flight or its result waits; results hold while rsp_stall is high.
module two_level_page_table #(
   parameter int unsigned TABLE_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_virt_addr,
   input  logic [31:0] req_phys_addr_in,
   input  logic [11:0] req_entry_flags,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_phys_addr_out,
   output logic [1:0]  rsp_status
);

   // Pool geometry; directory entries carry {slot, flags}
   localparam int unsigned SLOT_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int unsigned TU_W     = $clog2(TABLE_SLOTS + 1);
   localparam int unsigned TS_DEPTH = TABLE_SLOTS * tlpt_pkg::ENTRIES;
   localparam int unsigned TS_AW    = $clog2(TS_DEPTH);
   localparam int unsigned DIR_W    = SLOT_W + tlpt_pkg::OFF_W;
   localparam logic [TS_AW-1:0] CLR_LAST = TS_AW'(TS_DEPTH - 1);

   tlpt_pkg::state_type state_ff, state_in;

   logic [TS_AW-1:0]    clear_cnt_ff, clear_cnt_in;
   logic [TU_W-1:0]     tables_used_ff, tables_used_in;
   logic [1:0]          cmd_ff, cmd_in;
   logic [31:0]         va_ff, va_in;
   logic [tlpt_pkg::FRAME_W-1:0] pa_frame_ff, pa_frame_in;
   logic [tlpt_pkg::OFF_W-1:0]   flags_ff, flags_in;
   logic [31:0]         phys_out_ff, phys_out_in;
   logic [1:0]          status_ff, status_in;

   // Memory ports
   logic                           dir_wr_en;
   logic [tlpt_pkg::IDX_W-1:0]     dir_wr_addr;
   logic [DIR_W-1:0]               dir_wr_data;
   logic [tlpt_pkg::IDX_W-1:0]     dir_rd_addr;
   logic [DIR_W-1:0]               dir_rd_data;
   logic                           tab_wr_en;
   logic [TS_AW-1:0]               tab_wr_addr;
   logic [31:0]                    tab_wr_data;
   logic [TS_AW-1:0]               tab_rd_addr;
   logic [31:0]                    tab_rd_data;

   // Decoded fields of the held transaction and of the directory entry
   logic [tlpt_pkg::IDX_W-1:0] dir_idx;
   logic [tlpt_pkg::IDX_W-1:0] tab_idx;
   logic [SLOT_W-1:0]          dir_slot;
   logic                       dir_hit;
   logic                       pool_free;
   logic [SLOT_W-1:0]          new_slot;
   logic [31:0]                map_entry;
   logic                       clear_low;

   assign dir_idx   = va_ff[31:22];
   assign tab_idx   = va_ff[21:12];
   assign dir_slot  = dir_rd_data[DIR_W-1:tlpt_pkg::OFF_W];
   // A present entry whose slot lies outside the pool counts as absent
   assign dir_hit   = dir_rd_data[0] && (32'(dir_slot) < 32'(TABLE_SLOTS));
   assign pool_free = tables_used_ff < TU_W'(TABLE_SLOTS);
   assign new_slot  = SLOT_W'(tables_used_ff);
   assign map_entry = {pa_frame_ff, flags_ff | tlpt_pkg::FLAG_PRESENT};
   // Clearing pass is in the first table slot (also the directory range)
   assign clear_low = (clear_cnt_ff >> tlpt_pkg::IDX_W) == '0;

   tlpt_ram #(
      .WIDTH (DIR_W),
      .DEPTH (tlpt_pkg::ENTRIES)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_wr_en),
      .wr_addr (dir_wr_addr),
      .wr_data (dir_wr_data),
      .rd_addr (dir_rd_addr),
      .rd_data (dir_rd_data)
   );

   tlpt_ram #(
      .WIDTH (32),
      .DEPTH (TS_DEPTH)
   ) u_tab_ram (
      .clock   (clock),
      .wr_en   (tab_wr_en),
      .wr_addr (tab_wr_addr),
      .wr_data (tab_wr_data),
      .rd_addr (tab_rd_addr),
      .rd_data (tab_rd_data)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tlpt_pkg::ST_INIT: begin
            if (clear_cnt_ff == CLR_LAST) begin
               state_in = tlpt_pkg::ST_IDLE;
            end
         end
         tlpt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = tlpt_pkg::ST_DIR;
            end
         end
         tlpt_pkg::ST_DIR: begin
            if (cmd_ff == tlpt_pkg::CMD_TRANSLATE && dir_hit) begin
               state_in = tlpt_pkg::ST_TAB;
            end else begin
               state_in = tlpt_pkg::ST_RESP;
            end
         end
         tlpt_pkg::ST_TAB: begin
            state_in = tlpt_pkg::ST_RESP;
         end
         tlpt_pkg::ST_RESP: begin
            if (!rsp_stall) begin
               state_in = tlpt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tlpt_pkg::ST_INIT;
         end
      endcase
   end

   // Outputs, memory controls and register updates
   always_comb begin
      clear_cnt_in   = clear_cnt_ff;
      tables_used_in = tables_used_ff;
      cmd_in         = cmd_ff;
      va_in          = va_ff;
      pa_frame_in    = pa_frame_ff;
      flags_in       = flags_ff;
      phys_out_in    = phys_out_ff;
      status_in      = status_ff;

      dir_wr_en   = 1'b0;
      dir_wr_addr = dir_idx;
      dir_wr_data = {new_slot, flags_ff | tlpt_pkg::FLAG_PRESENT | tlpt_pkg::FLAG_RW};
      dir_rd_addr = dir_idx;
      tab_wr_en   = 1'b0;
      tab_wr_addr = TS_AW'({dir_slot, tab_idx});
      tab_wr_data = map_entry;
      tab_rd_addr = TS_AW'({dir_slot, tab_idx});

      req_stall = (state_ff != tlpt_pkg::ST_IDLE);
      rsp_valid = (state_ff == tlpt_pkg::ST_RESP);

      case (state_ff)
         tlpt_pkg::ST_INIT: begin
            // Sweep both memories with their reset contents
            clear_cnt_in = clear_cnt_ff + TS_AW'(1);
            tab_wr_en    = 1'b1;
            tab_wr_addr  = clear_cnt_ff;
            if (clear_low) begin
               tab_wr_data = {10'd0, clear_cnt_ff[tlpt_pkg::IDX_W-1:0],
                              tlpt_pkg::IDENT_FLAGS};
               dir_wr_en   = 1'b1;
               dir_wr_addr = clear_cnt_ff[tlpt_pkg::IDX_W-1:0];
               dir_wr_data = (clear_cnt_ff == '0) ?
                             {SLOT_W'(0), tlpt_pkg::DIR_FIRST} :
                             {SLOT_W'(0), tlpt_pkg::DIR_ABSENT};
            end else begin
               tab_wr_data = '0;
            end
         end
         tlpt_pkg::ST_IDLE: begin
            // Start the directory read straight off the request
            dir_rd_addr = req_virt_addr[31:22];
            if (req_valid) begin
               cmd_in      = req_command;
               va_in       = req_virt_addr;
               pa_frame_in = req_phys_addr_in[31:tlpt_pkg::OFF_W];
               flags_in    = req_entry_flags;
            end
         end
         tlpt_pkg::ST_DIR: begin
            phys_out_in = '0;
            status_in   = tlpt_pkg::STAT_DONE;
            case (cmd_ff)
               tlpt_pkg::CMD_MAP: begin
                  if (dir_hit) begin
                     tab_wr_en = 1'b1;
                  end else if (pool_free) begin
                     // Fresh slot: untouched since the clearing pass
                     dir_wr_en      = 1'b1;
                     tab_wr_en      = 1'b1;
                     tab_wr_addr    = TS_AW'({new_slot, tab_idx});
                     tables_used_in = tables_used_ff + TU_W'(1);
                  end else begin
                     status_in = tlpt_pkg::STAT_NO_TABLE;
                  end
               end
               tlpt_pkg::CMD_UNMAP: begin
                  tab_wr_en   = dir_hit;
                  tab_wr_data = '0;
               end
               tlpt_pkg::CMD_TRANSLATE: begin
                  if (!dir_hit) begin
                     status_in = tlpt_pkg::STAT_UNMAPPED;
                  end
               end
               default: begin
                  status_in = tlpt_pkg::STAT_DONE;
               end
            endcase
         end
         tlpt_pkg::ST_TAB: begin
            if (tab_rd_data[0]) begin
               phys_out_in = {tab_rd_data[31:tlpt_pkg::OFF_W],
                              va_ff[tlpt_pkg::OFF_W-1:0]};
               status_in   = tlpt_pkg::STAT_DONE;
            end else begin
               phys_out_in = '0;
               status_in   = tlpt_pkg::STAT_UNMAPPED;
            end
         end
         tlpt_pkg::ST_RESP: begin
            // Hold the result until it is taken
         end
         default: begin
         end
      endcase
   end

   assign rsp_phys_addr_out = phys_out_ff;
   assign rsp_status        = status_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tlpt_pkg::ST_INIT;
         clear_cnt_ff   <= '0;
         tables_used_ff <= TU_W'(1);
      end else begin
         state_ff       <= state_in;
         clear_cnt_ff   <= clear_cnt_in;
         tables_used_ff <= tables_used_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      va_ff       <= va_in;
      pa_frame_ff <= pa_frame_in;
      flags_ff    <= flags_in;
      phys_out_ff <= phys_out_in;
      status_ff   <= status_in;
   end

   // Never take a new transaction while a result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result is pending");

   // The pool only grows and never passes its size
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != tlpt_pkg::ST_INIT) |=>
         (tables_used_ff >= $past(tables_used_ff)) &&
         (tables_used_ff <= TU_W'(TABLE_SLOTS)))
      else $error("table pool count out of order");

   // A refused map only happens with the pool used up
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == tlpt_pkg::STAT_NO_TABLE) |->
         (tables_used_ff == TU_W'(TABLE_SLOTS)))
      else $error("map refused with free table slots");

   // A non-zero address only comes with a successful walk
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_phys_addr_out != '0) |->
         (rsp_status == tlpt_pkg::STAT_DONE && cmd_ff == tlpt_pkg::CMD_TRANSLATE))
      else $error("address returned without a translation");

endmodule

### tb/sv/page_walk_checker.sv
`timescale 1ns / 1ps

module page_walk_checker #(
   parameter int unsigned TABLE_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_virt_addr,
   input  logic [31:0] req_phys_addr_in,
   input  logic [11:0] req_entry_flags,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_phys_addr_out,
   input  logic [1:0]  rsp_status,

   output int          mismatch_count,
   output int          results_outstanding,
   output int          transactions_seen,
   output int          translate_hits,
   output int          translate_misses,
   output int          map_refusals
);

   typedef struct packed {
      logic [31:0]          phys_addr;
      tlpt_pkg::status_type status;
   } walk_result_type;

   // Shadow copy of both levels: directory holds {slot, flags}
   logic [16:0]     directory_copy [tlpt_pkg::ENTRIES];
   logic [31:0]     table_pool [TABLE_SLOTS*tlpt_pkg::ENTRIES];
   int unsigned     slots_taken;
   walk_result_type results_due [$];
   walk_result_type want;

   int mismatches = 0;
   int accepted   = 0;
   int hits       = 0;
   int misses     = 0;
   int refusals   = 0;

   function automatic void load_reset_image();
      int i;
      for (i = 0; i < tlpt_pkg::ENTRIES; i++)
         directory_copy[i] = {5'd0, tlpt_pkg::DIR_ABSENT};
      directory_copy[0] = {5'd0, tlpt_pkg::DIR_FIRST};
      for (i = 0; i < TABLE_SLOTS*tlpt_pkg::ENTRIES; i++) table_pool[i] = '0;
      for (i = 0; i < tlpt_pkg::ENTRIES; i++)
         table_pool[i] = {i[19:0], tlpt_pkg::IDENT_FLAGS};
      slots_taken = 1;
   endfunction

   // A directory entry leads to a table only when present and in the pool
   function automatic logic find_table(input logic [9:0] dir_idx, output int unsigned slot);
      logic [16:0] entry;
      entry = directory_copy[dir_idx];
      slot  = 32'(entry[16:12]);
      return entry[0] && (slot < TABLE_SLOTS);
   endfunction

   function automatic walk_result_type page_walk(input logic [1:0]  cmd,
                                                 input logic [31:0] va,
                                                 input logic [31:0] pa,
                                                 input logic [11:0] fl);
      walk_result_type r;
      logic [9:0]      di;
      logic [9:0]      ti;
      int unsigned     slot;
      logic            found;
      logic [31:0]     te;
      int              i;
      di          = va[31:22];
      ti          = va[21:12];
      r.phys_addr = '0;
      r.status    = tlpt_pkg::STAT_DONE;
      case (cmd)
         tlpt_pkg::CMD_MAP: begin
            found = find_table(di, slot);
            if (!found) begin
               if (slots_taken < TABLE_SLOTS) begin
                  slot = slots_taken;
                  slots_taken++;
                  for (i = 0; i < tlpt_pkg::ENTRIES; i++)
                     table_pool[slot*tlpt_pkg::ENTRIES + i] = '0;
                  directory_copy[di] = {slot[4:0],
                                        fl | tlpt_pkg::FLAG_PRESENT | tlpt_pkg::FLAG_RW};
                  found = 1'b1;
               end else begin
                  r.status = tlpt_pkg::STAT_NO_TABLE;
               end
            end
            if (found)
               table_pool[slot*tlpt_pkg::ENTRIES + ti] =
                  {pa[31:12], fl | tlpt_pkg::FLAG_PRESENT};
         end
         tlpt_pkg::CMD_UNMAP: begin
            if (find_table(di, slot)) table_pool[slot*tlpt_pkg::ENTRIES + ti] = '0;
         end
         tlpt_pkg::CMD_TRANSLATE: begin
            found = find_table(di, slot);
            te    = found ? table_pool[slot*tlpt_pkg::ENTRIES + ti] : '0;
            if (te[0])
               r.phys_addr = {te[31:12], va[11:0]};
            else
               r.status = tlpt_pkg::STAT_UNMAPPED;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic flag_result(input string why, input walk_result_type exp_result);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: %s: phys_addr_out exp %h got %h, status exp %0d got %0d",
                  $time, why, exp_result.phys_addr, rsp_phys_addr_out,
                  exp_result.status, rsp_status);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         load_reset_image();
         results_due.delete();
      end else begin
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            want = page_walk(req_command, req_virt_addr, req_phys_addr_in, req_entry_flags);
            results_due.push_back(want);
            accepted++;
            if (req_command == tlpt_pkg::CMD_TRANSLATE) begin
               if (want.status == tlpt_pkg::STAT_DONE) hits++;
               else misses++;
            end
            if (want.status == tlpt_pkg::STAT_NO_TABLE) refusals++;
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (results_due.size() == 0) begin
               flag_result("result with nothing outstanding", '0);
            end else begin
               want = results_due.pop_front();
               if (rsp_phys_addr_out !== want.phys_addr || rsp_status !== want.status)
                  flag_result("result mismatch", want);
            end
         end
      end
      mismatch_count      <= mismatches;
      results_outstanding <= results_due.size();
      transactions_seen   <= accepted;
      translate_hits      <= hits;
      translate_misses    <= misses;
      map_refusals        <= refusals;
   end

endmodule

### tb/sv/tb_two_level_page_table.sv
`timescale 1ns / 1ps

module tb_two_level_page_table;

   localparam int unsigned TABLE_SLOTS = 16;
   // The command field is two bits wide; the fourth code is unused by the block
   localparam logic [1:0]  CMD_SPARE   = 2'd3;
   localparam int          RANDOM_ITEMS = 650;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command      = '0;
   logic [31:0] req_virt_addr    = '0;
   logic [31:0] req_phys_addr_in = '0;
   logic [11:0] req_entry_flags  = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [31:0] rsp_phys_addr_out;
   logic [1:0]  rsp_status;

   int mismatch_count;
   int results_outstanding;
   int transactions_seen;
   int translate_hits;
   int translate_misses;
   int map_refusals;

   // Burst enables for each side; both drop to zero for the closing stretch
   bit gap_bursts   = 1'b1;
   bit stall_bursts = 1'b1;
   int requests_sent = 0;

   // A few directory and table indexes that random traffic keeps returning to,
   // so that maps land in tables that exist and translations find live pages
   logic [9:0] hot_dirs [20];
   logic [9:0] hot_tabs [12];

   two_level_page_table #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_virt_addr     (req_virt_addr),
      .req_phys_addr_in  (req_phys_addr_in),
      .req_entry_flags   (req_entry_flags),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_phys_addr_out (rsp_phys_addr_out),
      .rsp_status        (rsp_status)
   );

   page_walk_checker #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) walk_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_virt_addr       (req_virt_addr),
      .req_phys_addr_in    (req_phys_addr_in),
      .req_entry_flags     (req_entry_flags),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_phys_addr_out   (rsp_phys_addr_out),
      .rsp_status          (rsp_status),
      .mismatch_count      (mismatch_count),
      .results_outstanding (results_outstanding),
      .transactions_seen   (transactions_seen),
      .translate_hits      (translate_hits),
      .translate_misses    (translate_misses),
      .map_refusals        (map_refusals)
   );

   always #5 clock = ~clock;

   // Hard stop: the clearing pass after reset and even the slowest run of all
   // transactions stay far below this bound
   initial begin
      #2_000_000;
      $display("[two_level_page_table] ERROR");
      $finish;
   end

   // Stall the result channel in short random bursts while enabled
   initial begin
      forever begin
         @(posedge clock);
         if (stall_bursts && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Present one transaction and hold it until the block takes it. An optional
   // idle burst goes first; valid stays high between back-to-back transactions.
   task automatic issue_request(input logic [1:0]  cmd,
                                input logic [31:0] va,
                                input logic [31:0] pa,
                                input logic [11:0] fl);
      if (gap_bursts && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_virt_addr    <= va;
      req_phys_addr_in <= pa;
      req_entry_flags  <= fl;
      do @(posedge clock); while (req_stall !== 1'b0);
      requests_sent++;
   endtask

   // Drop valid and hold off until the checker has nothing outstanding.
   // The counters are registered, so always advance before looking.
   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (results_outstanding != 0 && waited < 5000);
   endtask

   function automatic logic [9:0] pick_dir();
      if ($urandom_range(0, 9) < 7) return hot_dirs[$urandom_range(0, 19)];
      return 10'($urandom);
   endfunction

   function automatic logic [9:0] pick_tab();
      if ($urandom_range(0, 9) < 6) return hot_tabs[$urandom_range(0, 11)];
      return 10'($urandom);
   endfunction

   function automatic logic [1:0] pick_command();
      int unsigned w;
      w = $urandom_range(0, 99);
      if (w < 30) return tlpt_pkg::CMD_MAP;
      if (w < 45) return tlpt_pkg::CMD_UNMAP;
      if (w < 97) return tlpt_pkg::CMD_TRANSLATE;
      return CMD_SPARE;
   endfunction

   // Random traffic: about a third of the picks are map-then-translate and unmap-then-translate pairs
   // on the same page, the rest single transactions of any command
   task automatic run_random(input int stop_at);
      int unsigned scenario;
      logic [31:0] va;
      while (requests_sent < stop_at) begin
         scenario = $urandom_range(0, 99);
         va       = {pick_dir(), pick_tab(), 12'($urandom)};
         if (scenario < 25) begin
            issue_request(tlpt_pkg::CMD_MAP, va, $urandom, 12'($urandom));
            issue_request(tlpt_pkg::CMD_TRANSLATE, {va[31:12], 12'($urandom)},
                          $urandom, 12'($urandom));
         end else if (scenario < 35) begin
            issue_request(tlpt_pkg::CMD_UNMAP, va, $urandom, 12'($urandom));
            issue_request(tlpt_pkg::CMD_TRANSLATE, va, $urandom, 12'($urandom));
         end else begin
            issue_request(pick_command(), va, $urandom, 12'($urandom));
         end
      end
   endtask

   initial begin
      int directed_count;
      int i;

      hot_dirs[0] = 10'd0;
      hot_dirs[1] = 10'h3FF;
      hot_dirs[2] = 10'd1;
      for (i = 3; i < 20; i++) hot_dirs[i] = 10'($urandom);
      hot_tabs[0] = 10'd0;
      hot_tabs[1] = 10'h3FF;
      for (i = 2; i < 12; i++) hot_tabs[i] = 10'($urandom);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset image: directory entry 0 identity-maps the first 4 MB.
      // Hit the last entry with the top offset, then address zero.
      issue_request(tlpt_pkg::CMD_TRANSLATE, 32'h003F_FFFF, '0, '0);
      issue_request(tlpt_pkg::CMD_TRANSLATE, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
      // Absent directory entry: translate misses, unmap leaves everything alone
      issue_request(tlpt_pkg::CMD_TRANSLATE, 32'hFFFF_FFFF, '0, '0);
      issue_request(tlpt_pkg::CMD_UNMAP, 32'hFFC0_0000, '0, '0);
      // Allocate a fresh table for the top directory entry, all-ones page
      issue_request(tlpt_pkg::CMD_MAP, 32'hFFFF_F000, 32'hFFFF_FFFF, 12'hFFF);
      issue_request(tlpt_pkg::CMD_TRANSLATE, 32'hFFFF_F123, '0, '0);
      // Fresh table must come up zeroed apart from the page just written
      issue_request(tlpt_pkg::CMD_TRANSLATE, 32'hFFC0_0ABC, '0, '0);
      // Overwrite an identity entry with zero flags; present bit gets forced
      issue_request(tlpt_pkg::CMD_MAP, 32'h0000_5000, 32'h0000_0FFF, 12'h000);
      issue_request(tlpt_pkg::CMD_TRANSLATE, 32'h0000_5FFF, '0, '0);
      issue_request(tlpt_pkg::CMD_UNMAP, 32'h0000_5000, '0, '0);
      issue_request(tlpt_pkg::CMD_TRANSLATE, 32'h0000_5000, '0, '0);
      // Alternating bit patterns through every field
      issue_request(tlpt_pkg::CMD_MAP, 32'h5555_5555, 32'hAAAA_AAAA, 12'h554);
      issue_request(tlpt_pkg::CMD_TRANSLATE, 32'h5555_5AAA, 32'h5555_5555, 12'hAAA);
      issue_request(tlpt_pkg::CMD_MAP, 32'hAAAA_AAAA, 32'h5555_5555, 12'hAAB);
      issue_request(tlpt_pkg::CMD_TRANSLATE, 32'hAAAA_A555, 32'hAAAA_AAAA, 12'h555);
      // Unused command code changes nothing; the top page still translates
      issue_request(CMD_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
      issue_request(tlpt_pkg::CMD_TRANSLATE, 32'hFFFF_FFFF, '0, '0);
      directed_count = requests_sent;

      // Let the pipeline run dry before random traffic starts
      settle();

      // Bursts on both sides; the pool runs out somewhere in here
      run_random(directed_count + 300);
      settle();

      // Sender streams back to back while the result side still stalls
      gap_bursts = 1'b0;
      run_random(directed_count + 500);

      // Closing stretch with no idling on either side
      stall_bursts = 1'b0;
      run_random(directed_count + RANDOM_ITEMS);

      settle();
      repeat (10) @(posedge clock);

      if (results_outstanding != 0)
         $display("%0d expected results never arrived", results_outstanding);
      $display("Covered %0d transactions: %0d translations hit, %0d missed",
               transactions_seen, translate_hits, translate_misses);
      $display("%0d maps refused after the table pool filled", map_refusals);
      if (mismatch_count == 0 && results_outstanding == 0)
         $display("[two_level_page_table] OK");
      else
         $display("[two_level_page_table] ERROR");
      $finish;
   end

endmodule

### files.f
hw/rtl/tlpt_pkg.sv
hw/rtl/tlpt_ram.sv
hw/rtl/two_level_page_table.sv
tb/sv/page_walk_checker.sv
tb/sv/tb_two_level_page_table.sv
